// ----- sv/bb3_pkg.sv -----
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int HEIGHT_CAP = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = COL_W + 1;
    // Row counter runs two rows past the frame while the tail drains.
    localparam int ROW_W      = $clog2(HEIGHT_CAP) + 1;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int RESET_WIDTH  = 800;
    localparam int RESET_HEIGHT = 600;

    localparam int PIX_W      = 32;
    localparam int RGB_W      = 24;
    localparam int CH_W       = 8;
    localparam int N_CH       = 3;
    localparam int WIN_H      = 3;
    localparam int SUM_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 10;
    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    // floor(s / 9) == (s * RECIP) >> RECIP_SH for every s below 2**SUM_W.
    localparam int RECIP      = 3641;
    localparam int RECIP_W    = 12;
    localparam int RECIP_SH   = 15;

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef logic [RGB_W-1:0] t_rgb;

    // Index 0: row y-2, index 1: row y-1, index 2: row y.
    typedef logic [WIN_H-1:0][RGB_W-1:0] t_colvec;

    // One line-memory word: the same column of the two most recent rows.
    typedef struct packed {
        t_rgb newer;
        t_rgb older;
    } t_pair;

    typedef struct packed {
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        t_rgb                 pix;
        logic                 use1;
        logic                 use2;
        logic                 x0;
        logic                 emit;
        logic [COL_W-1:0]     ocol;
        logic [OUT_ROW_W-1:0] orow;
        logic                 last;
    } t_step;

    typedef struct packed {
        logic [N_CH-1:0][SUM_W-1:0] sum;
        logic [COL_W-1:0]           ocol;
        logic [OUT_ROW_W-1:0]       orow;
        logic                       last;
    } t_sums;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 frame_last;
    } t_result;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] p;
        p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP);
        return p[RECIP_SH +: CH_W];
    endfunction

endpackage

// ----- sv/bb3_pix_if.sv -----
interface bb3_pix_if
    import bb3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output operation, output pixel_in, input ready);
    modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

// ----- sv/bb3_res_if.sv -----
interface bb3_res_if
    import bb3_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 frame_last;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input frame_last, output ready);
endinterface

// ----- sv/box_blur_3x3_stream_top.sv -----
// channel  | dir | handshake     | payload
// ---------+-----+---------------+-----------------------------------------------
// i_pix    | in  | valid / ready | operation (push / drain), pixel_in (ARGB)
// o_res    | out | valid / ready | pixel_out, out_col, out_row, frame_last
// i_cfg_*  | in  | i_cfg_we      | i_cfg_idx (0 width, 1 height), i_cfg_data
//
// Throughput: one beat per clock while the output queue has room, set by the
// single line-memory read/write per step. A step passes through r_s1 and r_s2
// into the 4-beat output queue. A one-row frame adds one internal step (one
// clock with i_pix.ready low) after its last push, before the drain tail.
// Reset: no clearing pass; the line memory is undefined until written and rows
// above the frame are masked by row position. A stalled o_res fills the queue,
// then i_pix.ready drops until room frees up.
module box_blur_3x3_stream_top
    import bb3_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bb3_pix_if.sink              i_pix,
    bb3_res_if.source            o_res
);

    // Frame geometry, already saturated to the legal range.
    logic [DIM_W-1:0]     r_w;
    logic [ROW_W-1:0]     r_h;

    // Step position (real pushes, then virtual zero rows while draining).
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    // Position of the next blurred pixel to go out.
    logic [COL_W-1:0]     r_ocol, n_ocol;
    logic [OUT_ROW_W-1:0] r_orow, n_orow;

    logic                 r_s1_vld;
    t_step                r_s1;
    logic                 r_s2_vld;
    t_sums                r_s2;

    t_colvec              r_wmid, r_wright;

    logic                 r_fwd_vld;
    logic [COL_W-1:0]     r_fwd_col;
    t_pair                r_fwd_data;

    t_result              r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]     r_wp, r_rp;
    logic [OQ_AW:0]       r_cnt;

    logic                 done, auto_go, space, accept, is_drain;
    logic                 step, emit, last, col_wrap, ocol_wrap;
    t_step                s0;
    logic [2*RGB_W-1:0]   ram_rdata;
    t_pair                s1_pair, s1_wdata;
    t_colvec              s1_col, s1_add;
    logic [N_CH-1:0][SUM_W-1:0] s1_sum;
    logic                 pop;

    // ------------------------------------------------------------------
    // Configuration: saturate and restart the frame.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= DIM_W'(RESET_WIDTH);
            r_h <= ROW_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w <= DIM_W'(1);
                    end else if (int'(i_cfg_data) > MAX_WIDTH) begin
                        r_w <= DIM_W'(MAX_WIDTH);
                    end else begin
                        r_w <= DIM_W'(i_cfg_data);
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h <= ROW_W'(1);
                    end else if (int'(i_cfg_data) > HEIGHT_CAP) begin
                        r_h <= ROW_W'(HEIGHT_CAP);
                    end else begin
                        r_h <= ROW_W'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, sequence the step, issue the line-memory read.
    // ------------------------------------------------------------------
    // Frame received once the step row reaches the height.
    assign done = (r_row >= r_h);
    // A one-row frame needs one extra virtual step at the start of row 1
    // before the first output lines up with a drain.
    assign auto_go = done && (r_row == ROW_W'(1)) && (r_col == '0);

    // Reserve a queue slot for every result still in flight.
    assign space = (int'(r_cnt) + int'(r_s1_vld && r_s1.emit) + int'(r_s2_vld)) < OQ_DEPTH;
    assign i_pix.ready = space && !auto_go;
    assign accept      = i_pix.valid && i_pix.ready;
    assign is_drain    = (t_op'(i_pix.operation) == OP_DRAIN);

    // Drop pushes after the frame is in and drains before it is.
    assign step = auto_go || (accept && (is_drain ? done : !done));
    assign emit = accept && (is_drain ? done
                  : (!done && (r_row != '0) && !((r_row == ROW_W'(1)) && (r_col == '0))));

    assign col_wrap  = (DIM_W'(r_col) + DIM_W'(1)) == r_w;
    assign ocol_wrap = (DIM_W'(r_ocol) + DIM_W'(1)) == r_w;
    assign last      = emit && ocol_wrap && ((ROW_W'(r_orow) + ROW_W'(1)) == r_h);

    always_comb begin
        s0.col  = r_col;
        s0.row  = r_row;
        s0.pix  = (accept && !is_drain) ? i_pix.pixel_in[RGB_W-1:0] : '0;
        s0.use1 = (r_row != '0);
        s0.use2 = (r_row >= ROW_W'(2));
        s0.x0   = (r_col == '0);
        s0.emit = emit;
        s0.ocol = r_ocol;
        s0.orow = r_orow;
        s0.last = last;
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (i_cfg_we || last) begin
            n_col  = '0;
            n_row  = '0;
            n_ocol = '0;
            n_orow = '0;
        end else begin
            if (step) begin
                if (col_wrap) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            if (emit) begin
                if (ocol_wrap) begin
                    n_ocol = '0;
                    n_orow = r_orow + OUT_ROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
            r_s1_vld <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s1 <= s0;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per column holding rows y-1 and y-2.
    // Read in stage 0, written back from stage 1 in the following clock.
    // ------------------------------------------------------------------
    bb3_ram #(
        .WIDTH (2*RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1.col),
        .i_wdata (s1_wdata),
        .i_re    (step),
        .i_raddr (s0.col),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: build the new column, shift the window, add up.
    // ------------------------------------------------------------------
    // Forward the write of the previous clock: with a one-pixel row the next
    // step reads the column being written on the same edge.
    assign s1_pair  = (r_fwd_vld && (r_fwd_col == r_s1.col)) ? r_fwd_data : t_pair'(ram_rdata);
    assign s1_wdata = {r_s1.pix, s1_pair.newer};

    always_comb begin
        s1_col[0] = r_s1.use2 ? s1_pair.older : '0;
        s1_col[1] = r_s1.use1 ? s1_pair.newer : '0;
        s1_col[2] = r_s1.pix;
        // At column 0 the pending output sits on the last column of its row,
        // so its right neighbor column lies outside the frame.
        s1_add    = r_s1.x0 ? '0 : s1_col;
    end

    always_comb begin
        s1_sum = '0;
        for (int ch = 0; ch < N_CH; ch++) begin
            for (int rw = 0; rw < WIN_H; rw++) begin
                s1_sum[ch] = s1_sum[ch]
                           + SUM_W'(r_wmid[rw][ch*CH_W +: CH_W])
                           + SUM_W'(r_wright[rw][ch*CH_W +: CH_W])
                           + SUM_W'(s1_add[rw][ch*CH_W +: CH_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_wmid     <= r_s1.x0 ? t_colvec'('0) : r_wright;
            r_wright   <= s1_col;
            r_fwd_col  <= r_s1.col;
            r_fwd_data <= s1_wdata;
            r_s2.sum   <= s1_sum;
            r_s2.ocol  <= r_s1.ocol;
            r_s2.orow  <= r_s1.orow;
            r_s2.last  <= r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
            r_s2_vld  <= 1'b0;
        end else begin
            r_fwd_vld <= r_s1_vld;
            r_s2_vld  <= r_s1_vld && r_s1.emit;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by nine, pack, and push into the output queue.
    // ------------------------------------------------------------------
    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_oq[r_wp].pixel_out  <= {ALPHA, div9(r_s2.sum[2]), div9(r_s2.sum[1]),
                                      div9(r_s2.sum[0])};
            r_oq[r_wp].out_col    <= OUT_COL_W'(r_s2.ocol);
            r_oq[r_wp].out_row    <= r_s2.orow;
            r_oq[r_wp].frame_last <= r_s2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s2_vld) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(r_s2_vld) - (OQ_AW+1)'(pop);
        end
    end

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.pixel_out  = r_oq[r_rp].pixel_out;
    assign o_res.out_col    = r_oq[r_rp].out_col;
    assign o_res.out_row    = r_oq[r_rp].out_row;
    assign o_res.frame_last = r_oq[r_rp].frame_last;

endmodule

// ----- sv/bb3_ram.sv -----
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- sv/bb3_chk.sv -----
module bb3_chk
    import bb3_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [PIX_W-1:0]     i_pixel_out,
    input logic [OUT_COL_W-1:0] i_out_col,
    input logic [OUT_ROW_W-1:0] i_out_row,
    input logic                 i_frame_last
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_out)
            && $stable(i_out_col) && $stable(i_out_row) && $stable(i_frame_last))
        else $error("result beat changed while stalled");

    // Reset empties the output queue.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat offered right after reset");

    // No beat can come out of the window this soon after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid ##1 !i_out_valid)
        else $error("result beat too early after reset");

    // Alpha is forced on every blurred pixel.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pixel_out[PIX_W-1 -: CH_W] == ALPHA)
        else $error("alpha not forced");

endmodule

bind box_blur_3x3_stream_top bb3_chk u_bb3_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_pixel_out  (o_res.pixel_out),
    .i_out_col    (o_res.out_col),
    .i_out_row    (o_res.out_row),
    .i_frame_last (o_res.frame_last)
);
